[rtl/core/mpd_pkg.sv]
package mpd_pkg;

  localparam int BYTE_W            = 8;
  localparam int BTN_W             = 3;
  localparam int CFG_W             = 16;
  localparam int CFG_IDX_W         = 1;
  localparam int POS_WIDTH_DEFAULT = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 1'b1;

  // Preset applied to both cursor coordinates at reset.
  localparam logic [CFG_W-1:0] START_RESET = 16'd200;

  // Bit 3 of the first byte of a packet is always set by the mouse.
  localparam logic [BYTE_W-1:0] SYNC_BIT   = 8'h08;
  localparam logic [BTN_W-1:0]  BTN_LEFT   = 3'h1;
  localparam logic [BTN_W-1:0]  BTN_RIGHT  = 3'h2;
  localparam logic [BTN_W-1:0]  BTN_MIDDLE = 3'h4;
  localparam logic [BTN_W-1:0]  BTN_MASK   = BTN_LEFT | BTN_RIGHT | BTN_MIDDLE;

endpackage

[rtl/core/mpd_decoder.sv]
module mpd_decoder #(
  parameter int POS_WIDTH = mpd_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_accept,
  input  logic [mpd_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          cfg_we,
  input  logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpd_pkg::CFG_W-1:0]     cfg_data,
  output logic [POS_WIDTH-1:0]          res_x,
  output logic [POS_WIDTH-1:0]          res_y,
  output logic [mpd_pkg::BTN_W-1:0]     res_held,
  output logic [mpd_pkg::BTN_W-1:0]     res_pressed,
  output logic [mpd_pkg::BTN_W-1:0]     res_released,
  output logic                          res_done,
  output logic                          res_dropped
);
  import mpd_pkg::*;

  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_THIRD  = 2'd2;

  logic [1:0]           byte_index, byte_index_next;
  logic [BYTE_W-1:0]    first_byte, first_byte_next;
  logic [BYTE_W-1:0]    second_byte, second_byte_next;
  logic [POS_WIDTH-1:0] cursor_x, cursor_x_next;
  logic [POS_WIDTH-1:0] cursor_y, cursor_y_next;
  logic [BTN_W-1:0]     button_state, button_state_next;
  logic [BTN_W-1:0]     now_buttons;
  logic [POS_WIDTH-1:0] delta_x, delta_y;

  assign now_buttons = first_byte[BTN_W-1:0] & BTN_MASK;
  assign delta_x     = POS_WIDTH'(signed'(second_byte));
  assign delta_y     = POS_WIDTH'(signed'(in_byte));

  always_comb begin
    byte_index_next   = byte_index;
    first_byte_next   = first_byte;
    second_byte_next  = second_byte;
    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    button_state_next = button_state;
    res_pressed       = '0;
    res_released      = '0;
    res_done          = 1'b0;
    res_dropped       = 1'b0;
    case (byte_index)
      IDX_FIRST: begin
        if ((in_byte & SYNC_BIT) == '0) begin
          res_dropped = 1'b1;
        end else begin
          first_byte_next = in_byte;
          byte_index_next = IDX_SECOND;
        end
      end
      IDX_SECOND: begin
        second_byte_next = in_byte;
        byte_index_next  = IDX_THIRD;
      end
      default: begin
        // The third byte, and the unused index code, complete the packet.
        cursor_x_next     = cursor_x + delta_x;
        cursor_y_next     = cursor_y - delta_y;
        res_pressed       = now_buttons & ~button_state & BTN_MASK;
        res_released      = button_state & ~now_buttons & BTN_MASK;
        button_state_next = now_buttons;
        byte_index_next   = IDX_FIRST;
        res_done          = 1'b1;
      end
    endcase
  end

  assign res_x    = cursor_x_next;
  assign res_y    = cursor_y_next;
  assign res_held = button_state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= IDX_FIRST;
      first_byte   <= '0;
      second_byte  <= '0;
      cursor_x     <= POS_WIDTH'(signed'(START_RESET));
      cursor_y     <= POS_WIDTH'(signed'(START_RESET));
      button_state <= '0;
    end else if (cfg_we) begin
      // A preset write loads the cursor coordinate at once.
      if (cfg_index == CFG_START_X) begin
        cursor_x <= POS_WIDTH'(signed'(cfg_data));
      end else begin
        cursor_y <= POS_WIDTH'(signed'(cfg_data));
      end
    end else if (in_accept) begin
      byte_index   <= byte_index_next;
      first_byte   <= first_byte_next;
      second_byte  <= second_byte_next;
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      button_state <= button_state_next;
    end
  end

endmodule

[rtl/core/mpd_out_skid.sv]
module mpd_out_skid #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              skid_valid;
  logic [DATA_W-1:0] skid_data;
  logic              in_accept;

  // Ready depends only on the skid register, so it is cut from out_ready.
  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_accept) begin
        out_data <= in_data;
      end
    end else if (in_accept) begin
      skid_data <= in_data;
    end
  end

endmodule

[rtl/core/ps2_mouse_packet_decoder.sv]
// Channel   Direction  Signals                          Carries
// s_*       in         s_tvalid s_tready s_tdata        one raw mouse byte per transaction
// m_*       out        m_tvalid m_tready m_tdata        cursor, buttons and edges per byte
//                      m_tlast m_tuser                  packet complete, byte dropped
// cfg_*     in         cfg_we cfg_index cfg_data        cursor x and y presets
//
// Each byte is decoded against the packet state in the cycle it is accepted, and its
// result is registered at the same edge, so a byte can be taken in every cycle while
// s_tready is high. The result is held in the output stage described below.
// Reset is synchronous and active high; both cursor coordinates come out of reset at
// 200. When the master side stalls, a two-entry output stage holds up to two results
// and s_tready falls only once both are occupied.
module ps2_mouse_packet_decoder #(
  parameter int POS_WIDTH = mpd_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mpd_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] byte_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // From the lowest bit up: pos_x, pos_y, buttons_held, pressed_now, released_now,
  // then zero padding to a whole byte.
  output logic [((2*POS_WIDTH+3*mpd_pkg::BTN_W+7)/8)*8-1:0] m_tdata,
  output logic                          m_tlast,   // packet_done
  output logic                          m_tuser,   // byte_dropped
  input  logic                          cfg_we,
  input  logic [mpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpd_pkg::CFG_W-1:0]     cfg_data
);
  import mpd_pkg::*;

  localparam int FIELD_W = 2*POS_WIDTH + 3*BTN_W;
  localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;
  // The result word also carries packet_done and byte_dropped at its top.
  localparam int RES_W   = TDATA_W + 2;

  logic                 s_accept;
  logic [POS_WIDTH-1:0] res_x, res_y;
  logic [BTN_W-1:0]     res_held, res_pressed, res_released;
  logic                 res_done, res_dropped;
  logic [RES_W-1:0]     res_word, out_word;

  assign s_accept = s_tvalid && s_tready;

  // Packet state and the decode of the current byte.
  mpd_decoder #(
    .POS_WIDTH(POS_WIDTH)
  ) u_decoder (
    .clk          (clk),
    .rst          (rst),
    .in_accept    (s_accept),
    .in_byte      (s_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .res_x        (res_x),
    .res_y        (res_y),
    .res_held     (res_held),
    .res_pressed  (res_pressed),
    .res_released (res_released),
    .res_done     (res_done),
    .res_dropped  (res_dropped)
  );

  assign res_word = {res_dropped, res_done,
                     TDATA_W'({res_released, res_pressed, res_held, res_y, res_x})};

  // Result register with a skid entry, so stalls on the master side do not
  // reach the slave side at once.
  mpd_out_skid #(
    .DATA_W(RES_W)
  ) u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (res_word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_word)
  );

  assign m_tdata = out_word[TDATA_W-1:0];
  assign m_tlast = out_word[TDATA_W];
  assign m_tuser = out_word[TDATA_W+1];

endmodule
